### rtl/core/sirt_pkg.sv
// ----------------------------------------------------------------------------
// sirt_pkg: shared definitions for the radix text converter
// Widths, character codes, register indexes and the alphabet bundle.
// ----------------------------------------------------------------------------
package sirt_pkg;

    localparam int MAX_SYMBOLS_DEF = 16;
    localparam int SYM_COUNT       = 16;
    localparam int SYM_IDX_W       = 4;
    localparam int DATA_W          = 32;
    localparam int STEP_BITS       = 8;
    localparam int DIGIT_CAP       = 32;
    localparam int CNT_W           = 6;
    localparam int RADIX_REG_W     = 5;
    localparam int CFG_DATA_W      = 64;
    localparam int REG_IDX_W       = 2;
    localparam int MIN_RADIX       = 2;

    localparam logic [7:0] MINUS_CHAR = 8'h2D;
    localparam logic [7:0] PLUS_CHAR  = 8'h2B;

    localparam logic [REG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_RADIX_LENGTH = 2'd2;

    typedef struct packed {
        logic                        alpha_ok;
        logic [RADIX_REG_W-1:0]      radix;
        logic [2*CFG_DATA_W-1:0]     symbols;
    } alpha_t;

endpackage

### rtl/core/sirt_if.sv
// ----------------------------------------------------------------------------
// sirt_if: handshake channels of the radix text converter
// Number input, text output and configuration write channels.
// ----------------------------------------------------------------------------
interface sirt_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [sirt_pkg::DATA_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

interface sirt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       final_char;

    modport source (output valid, output text_byte, output final_char, input ready);
    modport sink (input valid, input text_byte, input final_char, output ready);
endinterface

interface sirt_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [sirt_pkg::REG_IDX_W-1:0]      index;
    logic [sirt_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/sirt_cfg.sv
// ----------------------------------------------------------------------------
// sirt_cfg: alphabet registers and alphabet check
// Holds the symbol bytes and radix, and keeps a registered validity flag.
// ----------------------------------------------------------------------------
module sirt_cfg #(
    parameter int MAX_SYMBOLS = sirt_pkg::MAX_SYMBOLS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    sirt_cfg_if.sink         cfg,
    output sirt_pkg::alpha_t alpha
);

    logic [sirt_pkg::CFG_DATA_W-1:0]  sym_lo_reg;
    logic [sirt_pkg::CFG_DATA_W-1:0]  sym_hi_reg;
    logic [sirt_pkg::RADIX_REG_W-1:0] radix_reg;
    logic                             ok_reg;
    logic                             ok_next;
    logic [2*sirt_pkg::CFG_DATA_W-1:0] symbols;

    assign cfg.ready = 1'b1;
    assign symbols   = {sym_hi_reg, sym_lo_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_lo_reg <= '0;
            sym_hi_reg <= '0;
            radix_reg  <= '0;
            ok_reg     <= 1'b0;
        end
        else
        begin
            ok_reg <= ok_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    sirt_pkg::REG_SYMBOLS_LOW:  sym_lo_reg <= cfg.data;
                    sirt_pkg::REG_SYMBOLS_HIGH: sym_hi_reg <= cfg.data;
                    sirt_pkg::REG_RADIX_LENGTH:
                        radix_reg <= cfg.data[sirt_pkg::RADIX_REG_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        logic [7:0] sa;
        ok_next = (radix_reg >= sirt_pkg::RADIX_REG_W'(sirt_pkg::MIN_RADIX))
               && (radix_reg <= sirt_pkg::RADIX_REG_W'(MAX_SYMBOLS));
        for (int a = 0; a < MAX_SYMBOLS; a++)
        begin
            sa = symbols[8*a +: 8];
            if (sirt_pkg::RADIX_REG_W'(a) < radix_reg)
            begin
                if (sa == sirt_pkg::MINUS_CHAR || sa == sirt_pkg::PLUS_CHAR)
                    ok_next = 1'b0;
                for (int b = a + 1; b < MAX_SYMBOLS; b++)
                begin
                    if (sirt_pkg::RADIX_REG_W'(b) < radix_reg && symbols[8*b +: 8] == sa)
                        ok_next = 1'b0;
                end
            end
        end
    end

    assign alpha.alpha_ok = ok_reg;
    assign alpha.radix    = radix_reg;
    assign alpha.symbols  = symbols;

endmodule

### rtl/core/sirt_div_step.sv
// ----------------------------------------------------------------------------
// sirt_div_step: shared radix division step
// Runs a group of restoring division steps on a shifting work word.
// ----------------------------------------------------------------------------
module sirt_div_step #(
    parameter int MAX_SYMBOLS = sirt_pkg::MAX_SYMBOLS_DEF
) (
    input  logic [sirt_pkg::DATA_W-1:0]        work,
    input  logic [$clog2(MAX_SYMBOLS)-1:0]     rem,
    input  logic [$clog2(MAX_SYMBOLS+1)-1:0]   radix,
    output logic [sirt_pkg::DATA_W-1:0]        work_step,
    output logic [$clog2(MAX_SYMBOLS)-1:0]     rem_step
);

    localparam int RW = $clog2(MAX_SYMBOLS);
    localparam int CW = RW + 1;

    always_comb
    begin
        logic [CW-1:0]               trial;
        logic [sirt_pkg::DATA_W-1:0] w;
        logic [RW-1:0]               r;
        w = work;
        r = rem;
        for (int i = 0; i < sirt_pkg::STEP_BITS; i++)
        begin
            trial = {r, w[sirt_pkg::DATA_W-1]};
            w     = {w[sirt_pkg::DATA_W-2:0], 1'b0};
            if (trial >= CW'(radix))
            begin
                trial = trial - CW'(radix);
                w[0]  = 1'b1;
            end
            r = trial[RW-1:0];
        end
        work_step = w;
        rem_step  = r;
    end

endmodule

### rtl/core/sirt_seq.sv
// ----------------------------------------------------------------------------
// sirt_seq: conversion sequencer
// Takes a number, divides it digit by digit, stacks the digits and emits text.
// ----------------------------------------------------------------------------
module sirt_seq #(
    parameter int MAX_SYMBOLS = sirt_pkg::MAX_SYMBOLS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    sirt_in_if.sink          number,
    sirt_out_if.source       text,
    input  sirt_pkg::alpha_t alpha
);

    localparam int RW      = $clog2(MAX_SYMBOLS);
    localparam int RADIX_W = $clog2(MAX_SYMBOLS + 1);
    localparam int STACK_W = sirt_pkg::DIGIT_CAP * RW;
    localparam int CHUNKS  = sirt_pkg::DATA_W / sirt_pkg::STEP_BITS;
    localparam int CHUNK_W = $clog2(CHUNKS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_SIGN  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0]                    state_reg, state_next;
    logic                          neg_reg, neg_next;
    logic [sirt_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CHUNK_W-1:0]            chunk_reg, chunk_next;
    logic [sirt_pkg::DATA_W-1:0]   work_reg, work_next;
    logic [RW-1:0]                 rem_reg, rem_next;
    logic [STACK_W-1:0]            stack_reg, stack_next;
    logic [sirt_pkg::DATA_W-1:0]   step_work;
    logic [RW-1:0]                 step_rem;
    logic [RADIX_W-1:0]            radix;
    logic [7:0]                    sym [sirt_pkg::SYM_COUNT];

    assign radix = alpha.radix[RADIX_W-1:0];

    sirt_div_step #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_div_step (
        .work      (work_reg),
        .rem       (rem_reg),
        .radix     (radix),
        .work_step (step_work),
        .rem_step  (step_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            chunk_reg <= '0;
            neg_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            chunk_reg <= chunk_next;
            neg_reg   <= neg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg  <= work_next;
        rem_reg   <= rem_next;
        stack_reg <= stack_next;
    end

    always_comb
    begin
        state_next = state_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        chunk_next = chunk_reg;
        work_next  = work_reg;
        rem_next   = rem_reg;
        stack_next = stack_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (number.valid)
                begin
                    work_next  = number.value;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                neg_next = work_reg[sirt_pkg::DATA_W-1];
                if (!alpha.alpha_ok)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    if (work_reg[sirt_pkg::DATA_W-1])
                        work_next = '0 - work_reg;
                    rem_next   = '0;
                    chunk_next = '0;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                work_next  = step_work;
                rem_next   = step_rem;
                chunk_next = chunk_reg + 1'b1;
                if (chunk_reg == CHUNK_W'(CHUNKS - 1))
                begin
                    stack_next = {stack_reg[STACK_W-RW-1:0], step_rem};
                    cnt_next   = cnt_reg + 1'b1;
                    rem_next   = '0;
                    if (step_work == '0)
                        state_next = neg_reg ? S_SIGN : S_EMIT;
                end
            end
            S_SIGN:
            begin
                if (text.ready)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (text.ready)
                begin
                    stack_next = stack_reg >> RW;
                    cnt_next   = cnt_reg - 1'b1;
                    if (cnt_reg == sirt_pkg::CNT_W'(1))
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        for (int k = 0; k < sirt_pkg::SYM_COUNT; k++)
            sym[k] = alpha.symbols[8*k +: 8];
    end

    assign number.ready    = (state_reg == S_IDLE);
    assign text.valid      = (state_reg == S_SIGN) || (state_reg == S_EMIT);
    assign text.text_byte  = (state_reg == S_SIGN) ? sirt_pkg::MINUS_CHAR
                           : sym[sirt_pkg::SYM_IDX_W'(stack_reg[RW-1:0])];
    assign text.final_char = (state_reg == S_EMIT) && (cnt_reg == sirt_pkg::CNT_W'(1));

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(number.ready && text.valid))
        else $error("Input taken while text is being emitted.");

    a_final_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (text.valid && text.ready && text.final_char) |=> number.ready)
        else $error("Block did not return to idle after the last character.");

    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= sirt_pkg::CNT_W'(sirt_pkg::DIGIT_CAP))
        else $error("Digit count beyond capacity.");

    a_bad_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHECK && !alpha.alpha_ok) |=> number.ready)
        else $error("Invalid alphabet did not drop the item.");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (cnt_reg != '0))
        else $error("Emitting with an empty digit stack.");

endmodule

### rtl/core/signed_int_to_radix_text_top.sv
// ----------------------------------------------------------------------------
// signed_int_to_radix_text_top: signed integer to radix text converter
// Converts a signed 32-bit number to text in a configurable digit alphabet.
// ----------------------------------------------------------------------------
// One number is in flight at a time; ready on the number channel stays low
// until its last character has been taken. After acceptance a check state
// tests the alphabet and loads the magnitude; each digit is then produced by
// the shared eight-bit-per-cycle division unit working through the whole
// 32-bit word, and the text follows at one character per cycle (a leading
// minus sign first) when the text channel is not stalled.
// An invalid alphabet drops the number in the check state with no text.
module signed_int_to_radix_text_top #(
    parameter int MAX_SYMBOLS = sirt_pkg::MAX_SYMBOLS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    sirt_in_if.sink    number,
    sirt_out_if.source text,
    sirt_cfg_if.sink   cfg
);

    sirt_pkg::alpha_t alpha;

    sirt_cfg #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .alpha (alpha)
    );

    sirt_seq #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (number),
        .text   (text),
        .alpha  (alpha)
    );

endmodule
